[rtl/gau_pkg.sv]
package gau_pkg;

   // pipeline depth from input transaction to result register
   localparam int NUM_STAGES = 10;
   // register stages inside the exp unit
   localparam int EXP_STAGES = 5;
   localparam int EXP_TABLE_BITS_DEF = 6;

   // command codes carried in req_tuser
   localparam logic CMD_APPLY = 1'b0;
   localparam logic CMD_DERIV = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_CENTRE   = 2'd0;
   localparam logic [1:0] CSR_INV_VAR  = 2'd1;
   localparam logic [1:0] CSR_PEAK     = 2'd2;

   localparam logic [15:0] CENTRE_RESET  = 16'd0;
   localparam logic [15:0] INV_VAR_RESET = 16'd256;
   localparam logic [15:0] PEAK_RESET    = 16'd4096;

   // log2(e) in Q1.28
   localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
   // ln(2) in Q0.32
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   // integer exponent at which exp goes to zero
   localparam logic [4:0] EXP_SHIFT_LIMIT = 5'd17;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic                  out_valid;
   } pipe_ctl_type;

   function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
      logic [63:0] q;
      case (k)
         1: q = v;
         2: q = v / 2;
         3: q = v / 3;
         4: q = v / 4;
         5: q = v / 5;
         6: q = v / 6;
         7: q = v / 7;
         8: q = v / 8;
         9: q = v / 9;
         10: q = v / 10;
         11: q = v / 11;
         12: q = v / 12;
         13: q = v / 13;
         14: q = v / 14;
         default: q = v;
      endcase
      return q;
   endfunction

   // 2^(-i/2^tb) in Q1.16 via truncated taylor sum of exp(-i*ln2/2^tb)
   function automatic logic [16:0] pow2neg_entry(input int idx, input int tb);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] prod;
      longint      acc;
      logic [63:0] rnd;
      y = (64'(idx) * LN2_Q32) >> tb;
      if (y > 64'hFFFF_FFFF) begin
         y = 64'hFFFF_FFFF;
      end
      term = 64'd1 << 32;
      acc = longint'(term);
      for (int k = 1; k <= 14; k++) begin
         prod = (term * y) >> 32;
         term = div_small(prod, k);
         if ((k & 1) != 0) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      rnd = (64'(acc) + 64'd32768) >> 16;
      return rnd[16:0];
   endfunction

endpackage

[rtl/gau_pipe_ctrl.sv]
module gau_pipe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 out_ready,
   output gau_pkg::pipe_ctl_type ctl
);

   localparam int N = gau_pkg::NUM_STAGES;

   logic [N-1:0] valid_ff;
   logic [N-1:0] en;

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      en[N-1] = !valid_ff[N-1] || out_ready;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < N; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   assign ctl.en        = en;
   assign ctl.out_valid = valid_ff[N-1];

endmodule

[rtl/gau_exp_unit.sv]
module gau_exp_unit #(
   parameter int TABLE_BITS = gau_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic [gau_pkg::EXP_STAGES-1:0]  en,
   input  logic [47:0]                     arg_value,
   output logic [16:0]                     exp_value
);

   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam int IDX_HI     = 51;
   localparam int W_HI       = 51 - TABLE_BITS;

   // interpolation table of 2^(-i/N), one entry past the end
   logic [16:0] pow_tab [TABLE_SIZE+1];

   for (genvar gi = 0; gi <= TABLE_SIZE; gi++) begin : g_tab
      localparam logic [16:0] ENTRY = gau_pkg::pow2neg_entry(gi, TABLE_BITS);
      assign pow_tab[gi] = ENTRY;
   end

   // stage a: exponent partial products
   logic        big_ff;
   logic [42:0] ph_ff;
   logic [42:0] pl_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         big_ff <= |arg_value[47:36];
         ph_ff  <= 43'(arg_value[35:22]) * 43'(gau_pkg::LOG2E_Q28);
         pl_ff  <= 43'(arg_value[21:8]) * 43'(gau_pkg::LOG2E_Q28);
      end
   end

   // stage b: sum and split into shift, index and weight
   logic [56:0]           t_in;
   logic [4:0]            n_ff;
   logic                  zero_ff;
   logic [TABLE_BITS-1:0] idx_ff;
   logic [15:0]           w_ff;

   assign t_in = {ph_ff, 14'd0} + 57'(pl_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         n_ff    <= t_in[56:52];
         zero_ff <= big_ff || (t_in[56:52] >= gau_pkg::EXP_SHIFT_LIMIT);
         idx_ff  <= t_in[IDX_HI -: TABLE_BITS];
         w_ff    <= t_in[W_HI -: 16];
      end
   end

   // stage c: table lookup
   logic [TABLE_BITS:0] idx_nx;
   logic [16:0]         t0_ff;
   logic [16:0]         t1_ff;
   logic [15:0]         w_c_ff;
   logic [4:0]          n_c_ff;
   logic                zero_c_ff;

   assign idx_nx = {1'b0, idx_ff} + (TABLE_BITS+1)'(1);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         t0_ff     <= pow_tab[{1'b0, idx_ff}];
         t1_ff     <= pow_tab[idx_nx];
         w_c_ff    <= w_ff;
         n_c_ff    <= n_ff;
         zero_c_ff <= zero_ff;
      end
   end

   // stage d: interpolation product
   logic [16:0] diff_in;
   logic [32:0] prod_ff;
   logic [16:0] t0_d_ff;
   logic        ge_ff;
   logic [4:0]  n_d_ff;
   logic        zero_d_ff;

   assign diff_in = t0_ff - t1_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         prod_ff   <= 33'(diff_in) * 33'(w_c_ff);
         t0_d_ff   <= t0_ff;
         ge_ff     <= t0_ff >= t1_ff;
         n_d_ff    <= n_c_ff;
         zero_d_ff <= zero_c_ff;
      end
   end

   // stage e: interpolate and apply integer shift
   logic [16:0] ef_in;
   logic [16:0] e_ff;

   assign ef_in = ge_ff ? (t0_d_ff - prod_ff[32:16]) : t0_d_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         e_ff <= zero_d_ff ? '0 : (ef_in >> n_d_ff);
      end
   end

   assign exp_value = e_ff;

endmodule

[rtl/gaussian_activation_unit.sv]
// gaussian radial activation, one result per input transaction
// each req transaction passes through every pipeline stage to rsp_tvalid, stalls hold it
// throughput: one transaction per cycle while rsp is not stalled, set by the fully pipelined datapath
// every stage has its own valid bit, so bubbles fill while rsp is stalled
// reset: synchronous, clears all stage valid bits and loads register defaults
// (centre 0, inv_var_squared 1.0, peak_scale 1.0)
module gaussian_activation_unit #(
   parameter int EXP_TABLE_BITS = gau_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] x_value, [31:16] y_value
   input  logic        req_tuser,   // [0] cmd
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] result_value
   output logic        rsp_tuser,   // [0] saturated
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int LAST = gau_pkg::NUM_STAGES - 1;

   // ---------------------------------------------------------------
   // configuration registers, writes always taken
   // ---------------------------------------------------------------
   logic [15:0] centre_ff;
   logic [15:0] inv_var_ff;
   logic [15:0] peak_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_ff  <= gau_pkg::CENTRE_RESET;
         inv_var_ff <= gau_pkg::INV_VAR_RESET;
         peak_ff    <= gau_pkg::PEAK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gau_pkg::CSR_CENTRE:  centre_ff  <= csr_data;
            gau_pkg::CSR_INV_VAR: inv_var_ff <= csr_data;
            gau_pkg::CSR_PEAK:    peak_ff    <= csr_data;
            default: ;   // unknown index, dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // stage control: per-stage valid and enable
   // ---------------------------------------------------------------
   gau_pkg::pipe_ctl_type ctl;

   gau_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .ctl       (ctl)
   );

   assign req_tready = ctl.en[0];
   assign rsp_tvalid = ctl.out_valid;

   // command bit rides along with the data
   logic [LAST-1:0] cmd_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         cmd_ff[0] <= req_tuser;
      end
      for (int s = 1; s < LAST; s++) begin
         if (ctl.en[s]) begin
            cmd_ff[s] <= cmd_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 0: distance from centre and its magnitude
   // d spans [-65535, 65535], so |d| fits 16 bits
   // ---------------------------------------------------------------
   logic signed [16:0] d_in;
   logic [16:0]        ad_in;
   logic signed [16:0] d_ff;
   logic [15:0]        ad_ff;
   logic signed [15:0] y0_ff;

   assign d_in  = $signed({centre_ff[15], centre_ff}) - $signed({req_tdata[15], req_tdata[15:0]});
   assign ad_in = d_in[16] ? 17'(-d_in) : 17'(d_in);

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         d_ff  <= d_in;
         ad_ff <= ad_in[15:0];
         y0_ff <= $signed(req_tdata[31:16]);
      end
   end

   // ---------------------------------------------------------------
   // stage 1: d^2 for apply, d*k for derivative
   // ---------------------------------------------------------------
   logic signed [33:0] dk_in;
   logic [31:0]        sq_ff;
   logic signed [32:0] dk_ff;
   logic signed [15:0] y1_ff;

   assign dk_in = 34'(d_ff) * 34'($signed({1'b0, inv_var_ff}));

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         sq_ff <= 32'(ad_ff) * 32'(ad_ff);
         dk_ff <= dk_in[32:0];
         y1_ff <= y0_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: exp argument a = d^2*k (Q16.32), derivative d*k*y
   // ---------------------------------------------------------------
   logic [47:0]        arg_ff;
   logic signed [48:0] dky_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         arg_ff <= 48'(sq_ff) * 48'(inv_var_ff);
         dky_ff <= 49'(dk_ff) * 49'(y1_ff);
      end
   end

   // ---------------------------------------------------------------
   // stages 3 to 7: exp(-a) in Q1.16
   // ---------------------------------------------------------------
   logic [16:0] exp_value;

   gau_exp_unit #(
      .TABLE_BITS (EXP_TABLE_BITS)
   ) u_exp (
      .clock     (clock),
      .en        (ctl.en[7:3]),
      .arg_value (arg_ff),
      .exp_value (exp_value)
   );

   // derivative: 2*d*k*y in Q.32 rounded half up to Q.12, carried alongside
   logic signed [48:0] dky_rnd_in;
   logic signed [29:0] dv_ff [3:8];

   assign dky_rnd_in = dky_ff + 49'sd262144;

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         dv_ff[3] <= dky_rnd_in[48:19];
      end
      for (int s = 4; s <= 8; s++) begin
         if (ctl.en[s]) begin
            dv_ff[s] <= dv_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 8: peak scale times exp
   // ---------------------------------------------------------------
   logic signed [33:0] scaled_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[8]) begin
         scaled_ff <= 34'($signed(peak_ff)) * 34'($signed({1'b0, exp_value}));
      end
   end

   // ---------------------------------------------------------------
   // stage 9: round, select, saturate into the result register
   // ---------------------------------------------------------------
   logic signed [33:0] scaled_rnd_in;
   logic signed [29:0] v_in;
   logic [15:0]        out_data_ff;
   logic               out_sat_ff;

   assign scaled_rnd_in = scaled_ff + 34'sd32768;
   assign v_in = (cmd_ff[LAST-1] == gau_pkg::CMD_DERIV) ? dv_ff[8]
                                                         : 30'($signed(scaled_rnd_in[33:16]));

   always_ff @(posedge clock) begin
      if (ctl.en[LAST]) begin
         if (v_in > 30'sd32767) begin
            out_data_ff <= 16'h7FFF;
            out_sat_ff  <= 1'b1;
         end else if (v_in < -30'sd32768) begin
            out_data_ff <= 16'h8000;
            out_sat_ff  <= 1'b1;
         end else begin
            out_data_ff <= v_in[15:0];
            out_sat_ff  <= 1'b0;
         end
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_sat_ff;

endmodule

[rtl/gau_checker.sv]
module gau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a clipped result sits at one of the range ends
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000)
      else $error("saturation flag without clipped value");

   // an empty result register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

endmodule

bind gaussian_activation_unit gau_checker u_gau_checker (.*);

[tb/gaussian_activation_checker.sv]
`timescale 1ns / 1ps
module gaussian_activation_checker #(
   parameter int TABLE_BITS = gau_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] x_value, [31:16] y_value
   input  logic        req_tuser,   // [0] cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] result_value
   input  logic        rsp_tuser,   // [0] saturated
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          outstanding
);

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [15:0] value;
      logic        clipped;
   } activation_type;

   localparam logic    CMD_DERIV    = gau_pkg::CMD_DERIV;
   localparam u64_type LOG2E_Q28    = 64'd387270501;
   localparam u64_type LN2_Q32      = 64'd2977044472;
   localparam u64_type FRAC_MASK    = (64'd1 << 52) - 64'd1;
   localparam int      REPORT_LIMIT = 100;

   logic [15:0] centre_q;
   logic [15:0] inv_var_q;
   logic [15:0] peak_q;
   activation_type expected_activations[$];

   // 2^(-i/2^TABLE_BITS) in Q1.16 from a truncated taylor sum of exp(-i*ln2/2^TABLE_BITS)
   function automatic u64_type frac_pow2_q16(input u64_type i);
      u64_type y;
      u64_type term;
      longint acc;
      y = (i * LN2_Q32) >> TABLE_BITS;
      if (y > 64'hFFFF_FFFF) begin
         y = 64'hFFFF_FFFF;
      end
      term = 64'd1 << 32;
      acc = longint'(term);
      for (int n = 1; n <= 14; n++) begin
         term = ((term * y) >> 32) / u64_type'(n);
         if ((n % 2) == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return (u64_type'(acc) + 64'd32768) >> 16;
   endfunction

   // exp(-arg), arg in Q16.32, result in Q1.16
   function automatic u64_type decay_q16(input u64_type arg);
      u64_type t;
      u64_type whole;
      u64_type frac;
      u64_type idx;
      u64_type wt;
      u64_type lo;
      u64_type hi;
      u64_type ef;
      if (arg >= (64'd1 << 36)) begin
         return 64'd0;
      end
      t = (arg >> 8) * LOG2E_Q28;
      whole = t >> 52;
      if (whole >= 64'd17) begin
         return 64'd0;
      end
      frac = t & FRAC_MASK;
      idx = frac >> (52 - TABLE_BITS);
      wt = (frac >> (36 - TABLE_BITS)) & 64'hFFFF;
      lo = frac_pow2_q16(idx);
      hi = frac_pow2_q16(idx + 64'd1);
      ef = (lo >= hi) ? lo - (((lo - hi) * wt) >> 16) : lo;
      return ef >> whole;
   endfunction

   function automatic activation_type gaussian_response(input logic cmd, input logic [15:0] x,
                                                        input logic [15:0] y);
      activation_type r;
      longint d;
      longint v;
      u64_type ad;
      u64_type arg;
      d = longint'($signed(centre_q)) - longint'($signed(x));
      if (cmd != CMD_DERIV) begin
         ad = u64_type'((d < 0) ? -d : d);
         arg = ad * ad * u64_type'(inv_var_q);
         v = (longint'($signed(peak_q)) * longint'(decay_q16(arg)) + 32768) >>> 16;
      end else begin
         v = (2 * d * longint'(inv_var_q) * longint'($signed(y)) + 524288) >>> 20;
      end
      r.clipped = 1'b0;
      if (v > 32767) begin
         v = 32767;
         r.clipped = 1'b1;
      end else if (v < -32768) begin
         v = -32768;
         r.clipped = 1'b1;
      end
      r.value = 16'(v);
      return r;
   endfunction

   always @(posedge clock) begin
      activation_type want;
      if (reset) begin
         centre_q = gau_pkg::CENTRE_RESET;
         inv_var_q = gau_pkg::INV_VAR_RESET;
         peak_q = gau_pkg::PEAK_RESET;
         expected_activations.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_activations.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $error("result %0d arrived with nothing expected", $signed(rsp_tdata));
               end
            end else begin
               want = expected_activations.pop_front();
               if (rsp_tdata !== want.value) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $error("result_value: expected %0d, actual %0d",
                            $signed(want.value), $signed(rsp_tdata));
                  end
               end
               if (rsp_tuser !== want.clipped) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $error("saturated: expected %0d, actual %0d", want.clipped, rsp_tuser);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_activations.push_back(
               gaussian_response(req_tuser, req_tdata[15:0], req_tdata[31:16]));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gau_pkg::CSR_CENTRE: centre_q = csr_data;
               gau_pkg::CSR_INV_VAR: inv_var_q = csr_data;
               gau_pkg::CSR_PEAK: peak_q = csr_data;
               default: ;
            endcase
         end
      end
      outstanding = expected_activations.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

   // command codes carried in req_tuser
   localparam logic CMD_APPLY = gau_pkg::CMD_APPLY;
   localparam logic CMD_DERIV = gau_pkg::CMD_DERIV;
   // the one index the block has no register behind
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 190;
   // long enough to fill every pipeline stage and back up into the input
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] x_value, [31:16] y_value
   logic        req_tuser;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] result_value
   logic        rsp_tuser;   // [0] saturated
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   int          fail_count;
   int          outstanding;

   // random idling on both sides, switched off for one whole phase
   bit          gaps_on;
   // raised by the stimulus, cleared by the receiver once its hold-off is over
   bit          hold_rsp;
   // centre currently programmed, so random samples can cluster around it
   logic [15:0] centre_now;

   gaussian_activation_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   gaussian_activation_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready = !(gaps_on && ($urandom_range(99) < 8));
         end
      end
   end

   // one register write transaction; starts and ends at a falling edge
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_params(input logic [15:0] centre, input logic [15:0] inv_var,
                             input logic [15:0] peak);
      write_csr(gau_pkg::CSR_CENTRE, centre);
      write_csr(gau_pkg::CSR_INV_VAR, inv_var);
      write_csr(gau_pkg::CSR_PEAK, peak);
      centre_now = centre;
   endtask

   // one sample transaction; starts and ends at a falling edge, tvalid left high
   // so that a following sample goes out back to back
   task automatic push_sample(input logic cmd, input logic [15:0] x, input logic [15:0] y);
      while (gaps_on && ($urandom_range(99) < 8)) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {y, x};
      req_tuser = cmd;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop offering samples and wait until every result is back
   task automatic settle();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic random_phase(input int count);
      logic        cmd;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] offset;
      for (int i = 0; i < count; i++) begin
         cmd = $urandom_range(1) ? CMD_DERIV : CMD_APPLY;
         // small distances from the centre keep exp away from zero for most k
         offset = 16'($urandom) & 16'((32'd1 << $urandom_range(15, 2)) - 1);
         if ($urandom_range(99) < 65) begin
            x = $urandom_range(1) ? centre_now + offset : centre_now - offset;
         end else begin
            x = 16'($urandom);
         end
         y = ($urandom_range(3) == 0) ? 16'($urandom_range(511)) - 16'd256 : 16'($urandom);
         push_sample(cmd, x, y);
      end
   endtask

   initial begin
      logic [15:0] k_pick;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_APPLY;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = gau_pkg::CSR_CENTRE;
      csr_data = '0;
      gaps_on = 1'b1;
      hold_rsp = 1'b0;
      centre_now = gau_pkg::CENTRE_RESET;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // a write to the spare index must leave the reset values alone
      write_csr(CSR_SPARE, 16'h1234);

      // reset values: centre 0, k 1.0, peak 1.0
      push_sample(CMD_APPLY, 16'h0000, 16'h7FFF);   // peak of the curve, y ignored
      push_sample(CMD_APPLY, 16'h7FFF, 16'h0000);
      push_sample(CMD_APPLY, 16'h8000, 16'h8000);   // argument beyond 16, exp is zero
      push_sample(CMD_APPLY, 16'h1000, 16'h0000);   // exp(-1)
      push_sample(CMD_APPLY, 16'hC800, 16'h0000);   // integer exponent reaches 17
      push_sample(CMD_APPLY, 16'h3600, 16'h0000);   // integer exponent 16
      push_sample(CMD_APPLY, 16'h0001, 16'h0000);
      push_sample(CMD_DERIV, 16'h8000, 16'h7FFF);   // clips high
      push_sample(CMD_DERIV, 16'h7FFF, 16'h7FFF);   // clips low
      push_sample(CMD_DERIV, 16'h1000, 16'h1000);
      push_sample(CMD_DERIV, 16'h0000, 16'h8000);   // zero distance
      push_sample(CMD_DERIV, 16'hFFFF, 16'hFFFF);   // rounds to zero
      settle();

      // largest k, negative full-scale peak
      set_params(16'h7FFF, 16'hFFFF, 16'h8000);
      push_sample(CMD_APPLY, 16'h7FFF, 16'h1234);
      push_sample(CMD_APPLY, 16'h7FFE, 16'h0000);
      push_sample(CMD_APPLY, 16'h8000, 16'h0000);
      push_sample(CMD_DERIV, 16'h8000, 16'h8000);
      push_sample(CMD_DERIV, 16'h8000, 16'h7FFF);
      settle();

      // k of zero flattens the curve to the peak everywhere
      set_params(16'h8000, 16'h0000, 16'h7FFF);
      push_sample(CMD_APPLY, 16'h7FFF, 16'h0000);
      push_sample(CMD_APPLY, 16'h8000, 16'hFFFF);
      push_sample(CMD_DERIV, 16'h7FFF, 16'h7FFF);
      settle();

      set_params(16'h0000, 16'h0001, gau_pkg::PEAK_RESET);
      push_sample(CMD_APPLY, 16'h8000, 16'h0000);
      push_sample(CMD_DERIV, 16'h8000, 16'h8000);
      settle();

      // random phases, each under its own setting; the reset values and then the extremes come first
      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(2))
            0: k_pick = 16'($urandom_range(16, 1));
            1: k_pick = 16'($urandom_range(1023));
            default: k_pick = 16'($urandom);
         endcase
         case (p)
            0: set_params(gau_pkg::CENTRE_RESET, gau_pkg::INV_VAR_RESET, gau_pkg::PEAK_RESET);
            1: set_params(16'h8000, 16'hFFFF, 16'h7FFF);
            2: set_params(16'h7FFF, 16'h0000, 16'h8000);
            default: set_params(16'($urandom), k_pick, 16'($urandom));
         endcase
         // one phase runs at full rate on both sides
         gaps_on = (p != 3);
         // one phase starts behind a long result stall so the input backs up
         if (p == 4) begin
            hold_rsp = 1'b1;
         end
         random_phase(PHASE_ITEMS);
         settle();
      end

      // drain: anything still coming out now is unexpected
      repeat (gau_pkg::NUM_STAGES + 5) @(negedge clock);
      if (outstanding != 0) begin
         $error("%0d results never arrived", outstanding);
      end
      if ((fail_count == 0) && (outstanding == 0)) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
